// ----- rtl/core/fixed_partition_job_dispatcher_assert.svh -----
// Assertion macros shared by the checker of the job dispatcher.
`ifndef FIXED_PARTITION_JOB_DISPATCHER_ASSERT_SVH
`define FIXED_PARTITION_JOB_DISPATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define FPJD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dispatcher check failed");

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define FPJD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dispatcher check failed");

`endif

// ----- rtl/core/fpjd_pkg.sv -----
// Package of the job dispatcher: widths, codes, state type and internal structs.
`default_nettype none
package fpjd_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF    = 16;

	localparam int EXT_ID_W   = 16;
	localparam int CNT_W      = 16;
	localparam int CLASS_W    = 2;
	localparam int PART_W     = 2;
	localparam int QCOUNT_W   = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 80;

	localparam logic KIND_ARRIVE = 1'b0;
	localparam logic KIND_DONE   = 1'b1;

	localparam logic [PART_W-1:0] PART_A = 2'd0;
	localparam logic [PART_W-1:0] PART_B = 2'd1;
	localparam logic [PART_W-1:0] PART_C = 2'd2;

	localparam logic [CLASS_W-1:0] CLASS_C = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVENT,
		ST_READ,
		ST_OFFER,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic              complete;
		logic [PART_W-1:0] part;
		logic              fill;
		logic [PART_W-1:0] fill_slot;
	} slot_cmd_t;

	typedef struct packed {
		logic                completed;
		logic [EXT_ID_W-1:0] completed_id;
		logic                dropped;
		logic [2:0]          dispatch_mask;
		logic [QCOUNT_W-1:0] queue_count;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/core/fixed_partition_job_dispatcher.sv -----
// Top level of the fixed-partition job dispatcher with its output register.
//
//   channel  direction  tdata                                tuser
//   s_       in         job_id, job_class, partition         kind
//   m_       out        completed .. done_c (one per event)  -
//
// Events are accepted one at a time: a new event is taken only once the result of
// the last has entered the output register. The sequencer re-reads the queue
// memory's head entry after each dispatch to partition C or B and offers it to
// C, B, A in turn.
// arst_n empties the queue and the partitions and clears the done counters.
// A stalled result stays in the output register while the next event is processed.
`default_nettype none
module fixed_partition_job_dispatcher #(
	parameter int QUEUE_DEPTH = fpjd_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = fpjd_pkg::ID_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// job_id[15:0], job_class[17:16], partition[19:18], zero[23:20]
	input  wire [fpjd_pkg::IN_DATA_W-1:0]    s_tdata,
	// kind[0]
	input  wire                              s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// completed[0], completed_id[16:1], dropped[17], dispatch_mask[20:18],
	// occupied_mask[23:21], queue_count[28:24], done_a[44:29], done_b[60:45],
	// done_c[76:61], zero[79:77]
	output logic [fpjd_pkg::OUT_DATA_W-1:0]  m_tdata
);

	fpjd_pkg::slot_cmd_t        slot_cmd;
	fpjd_pkg::result_t          res;
	logic                       res_valid, res_ready;
	logic [ID_WIDTH-1:0]        fill_id, sel_id;
	logic [2:0]                 occupied;
	logic [fpjd_pkg::CNT_W-1:0] done_a, done_b, done_c;
	logic                       m_tvalid_q;
	logic [fpjd_pkg::OUT_DATA_W-1:0] m_tdata_q;

	fpjd_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH   (ID_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.kind     (s_tuser),
		.job_id   (s_tdata[15:0]),
		.job_class(s_tdata[17:16]),
		.partition(s_tdata[19:18]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.slot_cmd (slot_cmd),
		.fill_id  (fill_id),
		.occupied (occupied),
		.sel_id   (sel_id)
	);

	fpjd_slots #(
		.ID_WIDTH(ID_WIDTH)
	) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (slot_cmd),
		.fill_id (fill_id),
		.occupied(occupied),
		.sel_id  (sel_id),
		.done_a  (done_a),
		.done_b  (done_b),
		.done_c  (done_c)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {3'b000, done_c, done_b, done_a, res.queue_count, occupied,
				res.dispatch_mask, res.dropped, res.completed_id, res.completed};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/fpjd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module fpjd_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/fpjd_slots.sv -----
// Partition slots A, B and C: busy flags, held job ids and saturating done counters.
`default_nettype none
module fpjd_slots #(
	parameter int ID_WIDTH = fpjd_pkg::ID_WIDTH_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  fpjd_pkg::slot_cmd_t        cmd,
	input  wire [ID_WIDTH-1:0]         fill_id,
	output logic [2:0]                 occupied,
	output logic [ID_WIDTH-1:0]        sel_id,
	output logic [fpjd_pkg::CNT_W-1:0] done_a,
	output logic [fpjd_pkg::CNT_W-1:0] done_b,
	output logic [fpjd_pkg::CNT_W-1:0] done_c
);

	logic [2:0]                 valid_q;
	logic [ID_WIDTH-1:0]        ids_q  [3];
	logic [fpjd_pkg::CNT_W-1:0] done_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < 3; i++) begin
				done_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (cmd.complete && cmd.part == 2'(i)) begin
					valid_q[i] <= 1'b0;
					if (done_q[i] != '1) begin
						done_q[i] <= done_q[i] + 1'b1;
					end
				end else if (cmd.fill && cmd.fill_slot == 2'(i)) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.complete && cmd.part == 2'(i)) begin
				ids_q[i] <= '0;
			end else if (cmd.fill && cmd.fill_slot == 2'(i)) begin
				ids_q[i] <= fill_id;
			end
		end
	end

	always_comb begin
		unique case (cmd.part)
			fpjd_pkg::PART_A: sel_id = ids_q[0];
			fpjd_pkg::PART_B: sel_id = ids_q[1];
			fpjd_pkg::PART_C: sel_id = ids_q[2];
			default:          sel_id = '0;
		endcase
	end

	assign occupied = valid_q;
	assign done_a   = done_q[0];
	assign done_b   = done_q[1];
	assign done_c   = done_q[2];

endmodule
`default_nettype wire

// ----- rtl/core/fpjd_ctrl.sv -----
// Event sequencer: queue pointers, queue memory access, head offers and result assembly.
`default_nettype none
module fpjd_ctrl #(
	parameter int QUEUE_DEPTH = fpjd_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = fpjd_pkg::ID_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           kind,
	input  wire [fpjd_pkg::EXT_ID_W-1:0]  job_id,
	input  wire [fpjd_pkg::CLASS_W-1:0]   job_class,
	input  wire [fpjd_pkg::PART_W-1:0]    partition,
	output logic                          res_valid,
	input  wire                           res_ready,
	output fpjd_pkg::result_t             res,
	output fpjd_pkg::slot_cmd_t           slot_cmd,
	output logic [ID_WIDTH-1:0]           fill_id,
	input  wire [2:0]                     occupied,
	input  wire [ID_WIDTH-1:0]            sel_id
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = ID_WIDTH + fpjd_pkg::CLASS_W;

	fpjd_pkg::state_t state_q, state_d;

	logic [PW-1:0]                   head_q, tail_q;
	logic [QW-1:0]                   queued_q;
	logic                            kind_q;
	logic [ID_WIDTH-1:0]             id_q;
	logic [fpjd_pkg::CLASS_W-1:0]    cls_q;
	logic [fpjd_pkg::PART_W-1:0]     part_q;
	logic [fpjd_pkg::PART_W-1:0]     slot_q;
	logic                            completed_q, dropped_q;
	logic [fpjd_pkg::EXT_ID_W-1:0]   cid_q;
	logic [2:0]                      disp_q;

	logic                            ram_we, ram_re;
	logic [EW-1:0]                   ram_rdata;
	logic [fpjd_pkg::CLASS_W-1:0]    head_cls, eff_cls;
	logic                            full, do_complete, take;

	fpjd_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata({cls_q, id_q}),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign head_cls = ram_rdata[EW-1:ID_WIDTH];
	assign fill_id  = ram_rdata[ID_WIDTH-1:0];
	// Class code 3 behaves as class C.
	assign eff_cls  = (head_cls > fpjd_pkg::CLASS_C) ? fpjd_pkg::CLASS_C : head_cls;
	assign full     = (queued_q == QW'(QUEUE_DEPTH));

	// The slot index doubles as the highest class the slot accepts.
	assign take = (state_q == fpjd_pkg::ST_OFFER) && !occupied[slot_q]
		&& (queued_q != '0) && (eff_cls <= slot_q);

	assign do_complete = (state_q == fpjd_pkg::ST_EVENT) && (kind_q == fpjd_pkg::KIND_DONE)
		&& (part_q != 2'd3) && occupied[part_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpjd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		in_ready           = 1'b0;
		res_valid          = 1'b0;
		ram_we             = 1'b0;
		ram_re             = 1'b0;
		slot_cmd.complete  = do_complete;
		slot_cmd.part      = part_q;
		slot_cmd.fill      = take;
		slot_cmd.fill_slot = slot_q;
		unique case (state_q)
			fpjd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = fpjd_pkg::ST_EVENT;
				end
			end
			fpjd_pkg::ST_EVENT: begin
				ram_we  = (kind_q == fpjd_pkg::KIND_ARRIVE) && !full;
				state_d = fpjd_pkg::ST_READ;
			end
			fpjd_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = fpjd_pkg::ST_OFFER;
			end
			fpjd_pkg::ST_OFFER: begin
				if (slot_q == fpjd_pkg::PART_A) begin
					state_d = fpjd_pkg::ST_HOLD;
				end else if (take) begin
					state_d = fpjd_pkg::ST_READ;
				end
			end
			fpjd_pkg::ST_HOLD: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = fpjd_pkg::ST_IDLE;
				end
			end
			default: state_d = fpjd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			queued_q <= '0;
		end else if (ram_we) begin
			tail_q   <= ptr_next(tail_q);
			queued_q <= queued_q + 1'b1;
		end else if (take) begin
			head_q   <= ptr_next(head_q);
			queued_q <= queued_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_q      <= kind;
			id_q        <= ID_WIDTH'(job_id);
			cls_q       <= job_class;
			part_q      <= partition;
			completed_q <= 1'b0;
			dropped_q   <= 1'b0;
			cid_q       <= '0;
			disp_q      <= '0;
		end
		if (state_q == fpjd_pkg::ST_EVENT) begin
			slot_q    <= fpjd_pkg::PART_C;
			dropped_q <= (kind_q == fpjd_pkg::KIND_ARRIVE) && full;
			if (do_complete) begin
				completed_q <= 1'b1;
				cid_q       <= fpjd_pkg::EXT_ID_W'(sel_id);
			end
		end
		if (state_q == fpjd_pkg::ST_OFFER) begin
			if (take) begin
				disp_q[slot_q] <= 1'b1;
			end
			if (slot_q != fpjd_pkg::PART_A) begin
				slot_q <= slot_q - 1'b1;
			end
		end
	end

	assign res.completed     = completed_q;
	assign res.completed_id  = cid_q;
	assign res.dropped       = dropped_q;
	assign res.dispatch_mask = disp_q;
	assign res.queue_count   = fpjd_pkg::QCOUNT_W'(queued_q);

endmodule
`default_nettype wire

// ----- rtl/core/fpjd_checker.sv -----
// Port-level checker of the job dispatcher and its bind to the top level.
`default_nettype none
`include "fixed_partition_job_dispatcher_assert.svh"
module fpjd_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [fpjd_pkg::OUT_DATA_W-1:0]  m_tdata
);

	// A result waiting for the sink keeps its value.
	`FPJD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// A partition filled during the event must be busy afterwards.
	`FPJD_ASSERT_NOW(a_disp_busy, m_tvalid, (m_tdata[20:18] & ~m_tdata[23:21]) == 3'b000)

	// The finished id is zero whenever nothing completed.
	`FPJD_ASSERT_NOW(a_cid_zero, m_tvalid && !m_tdata[0], m_tdata[16:1] == 16'd0)

	// One event cannot both complete a job and drop an arrival.
	`FPJD_ASSERT_NOW(a_one_kind, m_tvalid, !(m_tdata[0] && m_tdata[17]))

endmodule

bind fixed_partition_job_dispatcher fpjd_checker u_fpjd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
